// ===== rtl/evpe_pkg.sv =====
// ----------------------------------------------------------------------------
// evpe_pkg
// Shared constants, codes and types of the encoder velocity and position
// estimator: filter coefficients, divider sizing, state and command types.
// ----------------------------------------------------------------------------
package evpe_pkg;

  // Fraction bits of the raw and filtered edge rate (counts per second).
  localparam int RATE_FRAC_BITS = 8;

  // Low-pass filter coefficients in Q0.16 and 2*pi in Q3.29.
  localparam logic [15:0] COEF_A     = 16'd55968;
  localparam logic [15:0] COEF_B     = 16'd4771;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  // Register reset values.
  localparam logic [15:0] CPR_RESET     = 16'd1024;
  localparam logic [31:0] TIMEOUT_RESET = 32'd100000;

  // Configuration register indexes.
  localparam int   CFG_IDX_W   = 1;
  localparam logic REG_CPR     = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  // Input opcodes.
  localparam logic OPC_EDGE   = 1'b0;
  localparam logic OPC_SAMPLE = 1'b1;

  // Shared divider: 64-bit dividend, 32-bit divisor, one quotient bit a cycle.
  localparam int DIV_W     = 64;
  localparam int DSR_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Edge rate dividend is 1e6 * 2^RATE_FRAC_BITS plus half the edge interval.
  localparam logic [63:0] RATE_NUM      = 64'd1000000 << RATE_FRAC_BITS;
  localparam int          RATE_DIV_BITS = $clog2(RATE_NUM + 64'h0000_0000_8000_0000);

  // Velocity and angle scaling shifts and quotient sizes.
  localparam int VEL_SHIFT    = 13 + RATE_FRAC_BITS;
  localparam int VEL_DIV_BITS = 65 - VEL_SHIFT;
  localparam int ANG_SHIFT    = 13;
  localparam int ANG_DIV_BITS = 64 - ANG_SHIFT;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_DIV,
    S_EDGE_WAIT,
    S_EDGE_WR,
    S_MUL_A,
    S_MUL_B,
    S_FILT,
    S_MUL_VEL,
    S_VEL_DIV,
    S_VEL_WAIT,
    S_VEL_WR,
    S_MUL_ANG,
    S_ANG_DIV,
    S_ANG_WAIT,
    S_ANG_WR
  } state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_EDGE_DIV,
    OP_EDGE_WR,
    OP_MUL_A,
    OP_MUL_B,
    OP_FILT,
    OP_MUL_VEL,
    OP_VEL_DIV,
    OP_VEL_WR,
    OP_MUL_ANG,
    OP_ANG_DIV,
    OP_ANG_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_busy;
  } status_t;

  // Divider start request.
  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DSR_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

endpackage

// ===== rtl/evpe_div.sv =====
// ----------------------------------------------------------------------------
// evpe_div
// Restoring bit-serial divider. The dividend arrives left-aligned so that
// only nbits steps are run; the quotient ends up in the low bits.
// ----------------------------------------------------------------------------
module evpe_div
  import evpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DSR_W-1:0]     rem_r, rem_nxt;
  logic [DSR_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [DSR_W+1:0]     trial;

  // One trial subtraction per cycle.
  assign trial = {1'b0, rem_r, quo_r[DIV_W-1]} - {2'b00, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = req.nbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DSR_W+1]) begin
        rem_nxt = trial[DSR_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DSR_W-2:0], quo_r[DIV_W-1]};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/evpe_dp.sv =====
// ----------------------------------------------------------------------------
// evpe_dp
// Datapath: configuration registers, estimator state, shared multiplier,
// shared divider and the output payload registers.
// ----------------------------------------------------------------------------
module evpe_dp
  import evpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic [31:0]          in_time_us,
  input  logic                 in_direction,
  output logic [31:0]          out_angular_velocity,
  output logic [31:0]          out_position_count,
  output logic [31:0]          out_position_angle
);

  // Configuration.
  logic [15:0] cpr_r;
  logic [31:0] timeout_r;

  // Estimator state.
  logic [31:0] last_edge_r;
  logic [31:0] raw_r;
  logic [31:0] prev_r;
  logic [31:0] filt_r;
  logic [31:0] count_r;

  // Latched item and working registers.
  logic        item_dir_r;
  logic [31:0] item_time_r;
  logic [31:0] r_r;
  logic [63:0] p_r;
  logic [48:0] acc_r;
  logic [31:0] vel_r;

  // Output payload.
  logic [31:0] out_vel_r;
  logic [31:0] out_cnt_r;
  logic [31:0] out_ang_r;

  logic [31:0]      dt;
  logic [15:0]      cpr_eff;
  logic [31:0]      mag;
  logic [32:0]      mul_a;
  logic [31:0]      mul_b;
  logic [64:0]      mul_p;
  logic [49:0]      fsum;
  logic [33:0]      fshift;
  logic [31:0]      filt_nxt;
  logic [63:0]      rate_val;
  logic [64:0]      vel_q;
  logic [64:0]      ang_q;
  logic [63:0]      vel_val;
  logic [63:0]      ang_val;
  logic [31:0]      quo_sat;
  logic [31:0]      ang_nxt;
  logic [DIV_W-1:0] quo;
  logic             div_busy;
  div_req_t         div_req;

  assign dt      = item_time_r - last_edge_r;
  assign cpr_eff = (cpr_r == 16'd0) ? 16'd1 : cpr_r;
  assign mag     = count_r[31] ? (32'd0 - count_r) : count_r;

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd.op)
      OP_MUL_A: begin
        mul_a = {1'b0, filt_r};
        mul_b = {16'd0, COEF_A};
      end
      OP_MUL_B: begin
        mul_a = {1'b0, r_r} + {1'b0, prev_r};
        mul_b = {16'd0, COEF_B};
      end
      OP_MUL_VEL: begin
        mul_a = {1'b0, filt_r};
        mul_b = TWO_PI_Q29;
      end
      OP_MUL_ANG: begin
        mul_a = {1'b0, mag};
        mul_b = TWO_PI_Q29;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 65'(mul_a) * 65'(mul_b);

  // Filter sum, rounding already folded into the accumulator.
  assign fsum     = 50'(acc_r) + 50'(p_r);
  assign fshift   = fsum[49:16];
  assign filt_nxt = (|fshift[33:32]) ? 32'hFFFF_FFFF : fshift[31:0];

  // Divider dividends with rounding offsets; the low shifts are exact floors.
  assign rate_val = RATE_NUM + 64'(dt[31:1]);
  assign vel_q    = 65'(p_r) + (65'(cpr_eff) << (VEL_SHIFT - 1));
  assign ang_q    = 65'(p_r) + (65'(cpr_eff) << (ANG_SHIFT - 1));
  assign vel_val  = 64'(vel_q >> VEL_SHIFT);
  assign ang_val  = 64'(ang_q >> ANG_SHIFT);

  always_comb begin
    div_req = '0;
    case (cmd.op)
      OP_EDGE_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = rate_val << (DIV_W - RATE_DIV_BITS);
        div_req.divisor  = dt;
        div_req.nbits    = DIV_CNT_W'(RATE_DIV_BITS);
      end
      OP_VEL_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = vel_val << (DIV_W - VEL_DIV_BITS);
        div_req.divisor  = 32'(cpr_eff);
        div_req.nbits    = DIV_CNT_W'(VEL_DIV_BITS);
      end
      OP_ANG_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = ang_val << (DIV_W - ANG_DIV_BITS);
        div_req.divisor  = 32'(cpr_eff);
        div_req.nbits    = DIV_CNT_W'(ANG_DIV_BITS);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  evpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Unsigned quotient clipped to 32 bits, and the signed angle.
  assign quo_sat = (|quo[63:32]) ? 32'hFFFF_FFFF : quo[31:0];

  always_comb begin
    if (count_r[31]) begin
      if (|quo[63:31]) begin
        ang_nxt = 32'h8000_0000;
      end else begin
        ang_nxt = 32'd0 - quo[31:0];
      end
    end else begin
      if (|quo[63:31]) begin
        ang_nxt = 32'h7FFF_FFFF;
      end else begin
        ang_nxt = quo[31:0];
      end
    end
  end

  // Configuration and estimator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r       <= CPR_RESET;
      timeout_r   <= TIMEOUT_RESET;
      last_edge_r <= '0;
      raw_r       <= '0;
      prev_r      <= '0;
      filt_r      <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CPR:     cpr_r     <= cfg_wdata[15:0];
          REG_TIMEOUT: timeout_r <= cfg_wdata;
          default:     cpr_r     <= cpr_r;
        endcase
      end
      case (cmd.op)
        OP_EDGE_WR: begin
          raw_r       <= status.dt_zero ? 32'hFFFF_FFFF : quo_sat;
          last_edge_r <= item_time_r;
          count_r     <= item_dir_r ? (count_r + 32'd1) : (count_r - 32'd1);
        end
        OP_MUL_A: begin
          // An idle encoder clears the raw rate from the next sample on.
          if (dt > timeout_r) begin
            raw_r <= '0;
          end
        end
        OP_FILT: begin
          filt_r <= filt_nxt;
          prev_r <= r_r;
        end
        default: begin
          raw_r <= raw_r;
        end
      endcase
    end
  end

  // Item and working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        item_time_r <= in_time_us;
        item_dir_r  <= in_direction;
      end
      OP_MUL_A: begin
        r_r <= raw_r;
        p_r <= mul_p[63:0];
      end
      OP_MUL_B: begin
        acc_r <= 49'(p_r[47:0]) + 49'd32768;
        p_r   <= mul_p[63:0];
      end
      OP_MUL_VEL, OP_MUL_ANG: begin
        p_r <= mul_p[63:0];
      end
      OP_VEL_WR: begin
        vel_r <= quo_sat;
      end
      OP_ANG_WR: begin
        out_vel_r <= vel_r;
        out_cnt_r <= count_r;
        out_ang_r <= ang_nxt;
      end
      default: begin
        p_r <= p_r;
      end
    endcase
  end

  assign status.dt_zero  = (dt == 32'd0);
  assign status.div_busy = div_busy;

  assign out_angular_velocity = out_vel_r;
  assign out_position_count   = out_cnt_r;
  assign out_position_angle   = out_ang_r;

endmodule

// ===== rtl/evpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// evpe_ctrl
// Controller: input and output handshakes and the sequence of datapath
// operations for edge events and sample requests.
// ----------------------------------------------------------------------------
module evpe_ctrl
  import evpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_opcode,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NOP;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = (in_opcode == OPC_SAMPLE) ? S_MUL_A : S_EDGE_DIV;
        end
      end
      S_EDGE_DIV: begin
        // Zero interval saturates without a division.
        if (status.dt_zero) begin
          state_nxt = S_EDGE_WR;
        end else begin
          cmd.op    = OP_EDGE_DIV;
          state_nxt = S_EDGE_WAIT;
        end
      end
      S_EDGE_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_EDGE_WR;
        end
      end
      S_EDGE_WR: begin
        cmd.op    = OP_EDGE_WR;
        state_nxt = S_IDLE;
      end
      S_MUL_A: begin
        cmd.op    = OP_MUL_A;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op    = OP_MUL_B;
        state_nxt = S_FILT;
      end
      S_FILT: begin
        cmd.op    = OP_FILT;
        state_nxt = S_MUL_VEL;
      end
      S_MUL_VEL: begin
        cmd.op    = OP_MUL_VEL;
        state_nxt = S_VEL_DIV;
      end
      S_VEL_DIV: begin
        cmd.op    = OP_VEL_DIV;
        state_nxt = S_VEL_WAIT;
      end
      S_VEL_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_VEL_WR;
        end
      end
      S_VEL_WR: begin
        cmd.op    = OP_VEL_WR;
        state_nxt = S_MUL_ANG;
      end
      S_MUL_ANG: begin
        cmd.op    = OP_MUL_ANG;
        state_nxt = S_ANG_DIV;
      end
      S_ANG_DIV: begin
        cmd.op    = OP_ANG_DIV;
        state_nxt = S_ANG_WAIT;
      end
      S_ANG_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_ANG_WR;
        end
      end
      S_ANG_WR: begin
        // Hold the finished result until the output register is free.
        if (out_free) begin
          cmd.op        = OP_ANG_WR;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/encoder_velocity_position_estimator.sv =====
// ----------------------------------------------------------------------------
// encoder_velocity_position_estimator
// Encoder edge-period rate estimator with IIR low-pass filter, position
// counter and angle and angular velocity outputs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): an item is an encoder edge
//   (in_opcode 0, with in_time_us and in_direction) or a sample request
//   (in_opcode 1, with in_time_us). A transfer happens on a clock edge with
//   in_valid high and in_stall low. Edges give no result; each sample
//   request gives one result on the output channel (out_valid / out_stall).
//   One item is processed at a time. An edge holds the block through its
//   rate division; a sample request through its filter step and its
//   velocity and angle divisions. The divisions run on the shared
//   bit-serial divider, which retires one quotient bit per cycle.
//   A result sits in an output register, so the next item is taken while it
//   waits. If the receiver stalls so long that the next result is ready,
//   that sample waits in its last step and input stays stalled.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once
//   and are to be made by the user while the block is idle; the block does not enforce this.
//   Synchronous reset clears the state, restores register defaults
//   (1024 counts per revolution, 100000 us timeout) and drops out_valid.
// ----------------------------------------------------------------------------
module encoder_velocity_position_estimator
  import evpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [31:0]          in_time_us,
  input  logic                 in_direction,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_angular_velocity,
  output logic signed [31:0]   out_position_count,
  output logic signed [31:0]   out_position_angle
);

  cmd_t        cmd;
  status_t     status;
  logic [31:0] pos_count;
  logic [31:0] pos_angle;

  evpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  evpe_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_time_us           (in_time_us),
    .in_direction         (in_direction),
    .out_angular_velocity (out_angular_velocity),
    .out_position_count   (pos_count),
    .out_position_angle   (pos_angle)
  );

  assign out_position_count = $signed(pos_count);
  assign out_position_angle = $signed(pos_angle);

endmodule

// ===== rtl/evpe_checker.sv =====
// ----------------------------------------------------------------------------
// evpe_checker
// Port-level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module evpe_checker
  import evpe_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_opcode,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [31:0]   out_position_count,
  input logic signed [31:0]   out_position_angle
);

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid not cleared by reset");

  // Items are processed one at a time: a transfer is followed by a stall.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  // No new result directly follows an encoder edge transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == OPC_EDGE) |=> !$rose(out_valid))
    else $error("result appeared right after an edge transfer");

  // A new result only appears at the end of a sample, while input is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in progress");

  // A stalled result holds its count and angle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_position_count) && $stable(out_position_angle)))
    else $error("stalled result changed");

endmodule

bind encoder_velocity_position_estimator evpe_checker u_evpe_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_opcode          (in_opcode),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_position_count (out_position_count),
  .out_position_angle (out_position_angle)
);

// ===== verif/encoder_velocity_position_estimator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_velocity_position_estimator_tb
// Drives encoder edges and sample requests into the estimator, under several
// register settings and idling patterns. Each sample report is checked field
// by field against a cycle-free predictor of rate, filter, count and angle.
// ----------------------------------------------------------------------------
module encoder_velocity_position_estimator_tb;
  import evpe_pkg::*;

  localparam int unsigned US_PER_S = 1000000;

  // One sample report as seen on the output channel.
  typedef struct packed {
    logic [31:0]        velocity;
    logic signed [31:0] count;
    logic signed [31:0] angle;
  } motion_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CPR;
  logic [31:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_opcode = OPC_EDGE;
  logic [31:0]          in_time_us = '0;
  logic                 in_direction = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [31:0]          out_angular_velocity;
  logic signed [31:0]   out_position_count;
  logic signed [31:0]   out_position_angle;

  // Predictor copy of the registers and state, at reset values.
  logic [15:0] est_cpr = CPR_RESET;
  logic [31:0] est_timeout = TIMEOUT_RESET;
  logic [31:0] est_last_edge = '0;
  logic [31:0] est_raw_rate = '0;
  logic [31:0] est_prev_rate = '0;
  logic [31:0] est_filtered = '0;
  logic [31:0] est_count = '0;

  motion_report_t pending_reports[$];
  motion_report_t want_report;

  logic [31:0] time_now = '0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int          error_count = 0;
  int          edges_sent = 0;
  int          samples_sent = 0;
  int          reports_checked = 0;
  int          config_writes = 0;

  encoder_velocity_position_estimator uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_time_us           (in_time_us),
    .in_direction         (in_direction),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_angular_velocity (out_angular_velocity),
    .out_position_count   (out_position_count),
    .out_position_angle   (out_position_angle)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Rounded division by counts per revolution scaled by 2^shift; zero acts as one.
  function automatic logic [127:0] divide_by_cpr(input logic [127:0] num,
                                                 input int unsigned shift);
    logic [127:0] den;
    den = (est_cpr == 16'd0 ? 128'd1 : 128'(est_cpr)) << shift;
    return (num + (den >> 1)) / den;
  endfunction

  // Applies one accepted item to the predictor; returns 1 when a report is due.
  function automatic bit advance_estimator(input logic op, input logic [31:0] t,
                                           input logic dir,
                                           output motion_report_t rpt);
    logic [31:0]  dt;
    logic [31:0]  held_rate;
    logic [31:0]  mag;
    logic [63:0]  acc;
    logic [127:0] scaled;
    dt = t - est_last_edge;
    rpt = '0;
    if (op == OPC_EDGE) begin
      // Edge rate is 1e6 / dt with half-up rounding; a zero interval saturates.
      if (dt == 32'd0) begin
        acc = 64'hFFFF_FFFF;
      end else begin
        acc = ((64'(US_PER_S) << RATE_FRAC_BITS) + 64'(dt >> 1)) / 64'(dt);
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      end
      est_raw_rate = acc[31:0];
      est_last_edge = t;
      est_count = dir ? est_count + 32'd1 : est_count - 32'd1;
      return 1'b0;
    end
    // The sample uses the rate held before any idle clear.
    held_rate = est_raw_rate;
    if (dt > est_timeout) est_raw_rate = '0;
    acc = 64'(COEF_A) * 64'(est_filtered)
        + 64'(COEF_B) * (64'(held_rate) + 64'(est_prev_rate)) + 64'd32768;
    acc = acc >> 16;
    est_filtered = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    est_prev_rate = held_rate;

    scaled = divide_by_cpr(128'(est_filtered) * TWO_PI_Q29, VEL_SHIFT);
    rpt.velocity = (scaled > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
    rpt.count = est_count;

    // Angle magnitude rounds away from zero, then saturates to the signed range.
    mag = est_count[31] ? -est_count : est_count;
    scaled = divide_by_cpr(128'(mag) * TWO_PI_Q29, ANG_SHIFT);
    if (est_count[31]) begin
      rpt.angle = (scaled >= 128'h8000_0000) ? 32'h8000_0000 : -scaled[31:0];
    end else begin
      rpt.angle = (scaled > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : scaled[31:0];
    end
    return 1'b1;
  endfunction

  task report_error(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Sends one item, idling first at random; returns on the transfer edge.
  task automatic send_item(input logic op, input logic [31:0] t, input logic dir);
    motion_report_t rpt;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_time_us <= t;
    in_direction <= dir;
    do @(posedge clk); while (in_stall);
    time_now = t;
    if (op == OPC_EDGE) edges_sent++;
    else samples_sent++;
    if (advance_estimator(op, t, dir, rpt)) pending_reports.push_back(rpt);
  endtask

  // Drops valid, waits for every pending report, then lets the datapath settle.
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes both registers on consecutive cycles; the block must be idle.
  task automatic write_config(input logic [31:0] cpr_word, input logic [31:0] timeout_word);
    cfg_we <= 1'b1;
    cfg_index <= REG_CPR;
    cfg_wdata <= cpr_word;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= timeout_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    est_cpr = cpr_word[15:0];
    est_timeout = timeout_word;
    config_writes++;
  endtask

  // Random item: mostly short intervals, with zero intervals, full-range jumps
  // and sample times right at the idle timeout boundary.
  task automatic send_random_item();
    logic        op;
    logic [31:0] t;
    op = ($urandom_range(99) < 30) ? OPC_SAMPLE : OPC_EDGE;
    case ($urandom_range(9))
      0: t = time_now;
      1: t = $urandom;
      2: t = est_last_edge + est_timeout + $urandom_range(0, 1);
      3: t = time_now + $urandom_range(1, 200000);
      default: t = time_now + $urandom_range(1, 3000);
    endcase
    send_item(op, t, 1'($urandom_range(1)));
  endtask

  // Field extremes, zero intervals, wrap-around and the timeout boundary.
  task automatic test_directed_corners();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_item(OPC_EDGE, 32'd0, 1'b1);
    send_item(OPC_SAMPLE, 32'd0, 1'b0);
    send_item(OPC_EDGE, 32'hFFFF_FFFF, 1'b0);
    send_item(OPC_EDGE, 32'd9, 1'b0);
    send_item(OPC_EDGE, 32'd9, 1'b0);
    send_item(OPC_SAMPLE, 32'd9, 1'b1);
    send_item(OPC_SAMPLE, 32'd9 + TIMEOUT_RESET, 1'b0);
    send_item(OPC_SAMPLE, 32'd10 + TIMEOUT_RESET, 1'b0);
    send_item(OPC_SAMPLE, 32'd11 + TIMEOUT_RESET, 1'b1);
    send_item(OPC_EDGE, 32'd200000, 1'b1);
    send_item(OPC_EDGE, 32'd200001, 1'b1);
    send_item(OPC_SAMPLE, 32'd200001, 1'b0);
    send_item(OPC_EDGE, 32'h8000_0000, 1'b1);
    send_item(OPC_SAMPLE, 32'h8000_0000, 1'b1);
    send_item(OPC_EDGE, 32'hFFFF_FFFF, 1'b1);
    send_item(OPC_EDGE, 32'hFFFF_FFFF, 1'b1);
    send_item(OPC_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    send_item(OPC_SAMPLE, 32'hFFFF_FFFF, 1'b1);
    send_item(OPC_SAMPLE, 32'h7FFF_FFFF, 1'b0);
  endtask

  // Register extremes: one count per rev, zero counts, the widest values, and
  // upper write-data bits that the count register must drop.
  task automatic test_register_extremes();
    tx_idle_pct = 24;
    rx_stall_pct = 24;
    for (int k = 0; k < 3; k++) begin
      wait_idle(150);
      case (k)
        0: write_config(32'd1, 32'd1);
        1: write_config(32'hFFFF_0000, 32'hFFFF_FFFF);
        default: write_config(32'h5A5A_FFFF, 32'd1000);
      endcase
      repeat (25) send_random_item();
    end
  endtask

  // Random traffic in four idling phases, each under a fresh register setting.
  task automatic test_random_traffic();
    logic [31:0] cpr_word;
    logic [31:0] timeout_word;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle(150);
      cpr_word = $urandom_range(1) ? $urandom : $urandom_range(1, 16);
      case ($urandom_range(2))
        0: timeout_word = $urandom;
        1: timeout_word = $urandom_range(1, 5000);
        default: timeout_word = $urandom_range(50000, 500000);
      endcase
      write_config(cpr_word, timeout_word);
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      repeat (180) send_random_item();
    end
  endtask

  // With one count per rev, a run of edges up and then a longer run down
  // swing the angle through several turns of both signs.
  task automatic test_count_ramp();
    wait_idle(150);
    write_config(32'd1, TIMEOUT_RESET);
    tx_idle_pct = 0;
    rx_stall_pct = 10;
    for (int n = 0; n < 60; n++) begin
      send_item(OPC_EDGE, time_now + $urandom_range(1, 50), 1'b1);
      if (n % 20 == 19) send_item(OPC_SAMPLE, time_now, 1'($urandom_range(1)));
    end
    send_item(OPC_SAMPLE, time_now + 1, 1'b0);
    for (int n = 0; n < 120; n++) begin
      send_item(OPC_EDGE, time_now + $urandom_range(1, 50), 1'b0);
      if (n % 20 == 19) send_item(OPC_SAMPLE, time_now, 1'($urandom_range(1)));
    end
    send_item(OPC_SAMPLE, time_now + 1, 1'b1);
  endtask

  // Checks every report transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_error("report transfer with no sample request pending");
      end else begin
        want_report = pending_reports.pop_front();
        if (out_angular_velocity !== want_report.velocity)
          report_error($sformatf("report %0d angular velocity %h, expected %h",
                                 reports_checked, out_angular_velocity,
                                 want_report.velocity));
        if (out_position_count !== want_report.count)
          report_error($sformatf("report %0d position count %h, expected %h",
                                 reports_checked, out_position_count, want_report.count));
        if (out_position_angle !== want_report.angle)
          report_error($sformatf("report %0d position angle %h, expected %h",
                                 reports_checked, out_position_angle, want_report.angle));
        reports_checked++;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_register_extremes();
    test_random_traffic();
    test_count_ramp();
    wait_idle(200);
    $display("Covered %0d encoder edges and %0d sample requests over %0d register settings,",
             edges_sent, samples_sent, config_writes + 1);
    $display("with idling and back-pressure phases; %0d reports checked, %0d errors.",
             reports_checked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, several times the slowest expected run.
  initial begin
    #5_000_000;
    $display("Run limit reached with %0d reports still pending.", pending_reports.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/evpe_pkg.sv
rtl/evpe_div.sv
rtl/evpe_dp.sv
rtl/evpe_ctrl.sv
rtl/encoder_velocity_position_estimator.sv
rtl/evpe_checker.sv
verif/encoder_velocity_position_estimator_tb.sv
